// ----- rtl/acfp_pkg.sv -----
// ----------------------------------------------------------------------------
// ASCII CAN frame parser package
// Beat types, character codes and limits shared by the parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package acfp_pkg;

  localparam int LINE_CHARS     = 32;
  localparam int MAX_DATA_BYTES = 8;

  localparam int CNT_W = $clog2(LINE_CHARS + 1);
  localparam int BC_W  = 4;
  localparam int ID_W  = 29;

  localparam logic [ID_W-1:0] EXT_ID_MAX   = 29'h1FFF_FFFF;
  localparam logic [ID_W-1:0] STD_ID_MAX   = 29'h0000_07FF;
  localparam logic [ID_W-1:0] ID_SHIFT_MAX = EXT_ID_MAX >> 4;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;

  typedef struct packed {
    logic [7:0] rx_char;
    logic       rx_error;
  } rx_beat_t;

  typedef struct packed {
    logic            is_extended;
    logic            is_remote;
    logic [ID_W-1:0] frame_id;
    logic [3:0]      frame_length;
    logic [63:0]     frame_data;
  } frame_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_0 && c <= CH_9) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF)) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ascii_can_frame_parser.sv -----
// ----------------------------------------------------------------------------
// ASCII CAN frame parser
// Parses ':' {X|S} id {N data | R len} ';' lines into CAN frame results.
// ----------------------------------------------------------------------------
// A ';' beat passes the input register; its frame then sits in the result register.
// Throughput: one character per cycle while out_stall is low.
// in_stall rises only when the input register is full and the result register
// is held by out_stall.
// Reset (rst_n low, synchronous) empties both registers and leaves the line idle.
`default_nettype none

module ascii_can_frame_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire acfp_pkg::rx_beat_t in_data,
  output logic                    in_stall,
  output logic                    out_valid,
  output acfp_pkg::frame_t        out_data,
  input  wire logic               out_stall
);
  import acfp_pkg::*;

  logic     beat_valid;
  logic     beat_take;
  rx_beat_t beat;

  acfp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_take  (beat_take)
  );

  acfp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_take  (beat_take),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_stall  (out_stall)
  );

endmodule

`default_nettype wire

// ----- rtl/acfp_in_reg.sv -----
// ----------------------------------------------------------------------------
// ASCII CAN frame parser input register
// Holds one received character beat until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module acfp_in_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire acfp_pkg::rx_beat_t in_data,
  output logic                   in_stall,
  output logic                   beat_valid,
  output acfp_pkg::rx_beat_t     beat,
  input  wire logic              beat_take
);
  import acfp_pkg::*;

  logic     valid_r, valid_nxt;
  rx_beat_t beat_r, beat_nxt;

  assign in_stall   = valid_r && !beat_take;
  assign beat_valid = valid_r;
  assign beat       = beat_r;

  always_comb begin
    valid_nxt = valid_r;
    beat_nxt  = beat_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
      if (in_valid) begin
        beat_nxt = in_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    beat_r <= beat_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/acfp_parser.sv -----
// ----------------------------------------------------------------------------
// ASCII CAN frame parser core
// Per-character frame state update and the frame result register.
// ----------------------------------------------------------------------------
`default_nettype none

module acfp_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               beat_valid,
  input  wire acfp_pkg::rx_beat_t beat,
  output logic                    beat_take,
  output logic                    out_valid,
  output acfp_pkg::frame_t        out_data,
  input  wire logic               out_stall
);
  import acfp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TYPE,
    PH_ID,
    PH_DATA,
    PH_RLEN,
    PH_TAIL
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic             in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ext_r, ext_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic             id_big_r, id_big_nxt;
  logic [63:0]      data_r, data_nxt;
  logic [BC_W-1:0]  bytes_r, bytes_nxt;
  logic [3:0]       hi_r, hi_nxt;
  logic             pend_r, pend_nxt;
  logic             remote_r, remote_nxt;
  logic [3:0]       rlen_r, rlen_nxt;
  logic             bad_r, bad_nxt;
  logic             out_valid_r, out_valid_nxt;
  frame_t           out_r, out_nxt;

  logic       out_ready;
  logic [4:0] hx;
  logic [7:0] c;
  logic       frame_ok;

  assign out_ready = !out_valid_r || !out_stall;
  assign beat_take = beat_valid && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign c         = beat.rx_char;
  assign hx        = hex_decode(c);

  assign frame_ok = !bad_r && (count_r < CNT_W'(LINE_CHARS)) && (count_r >= CNT_W'(3)) &&
                    (phase_r != PH_TYPE) && !pend_r && !id_big_r &&
                    (ext_r || (id_r <= STD_ID_MAX));

  always_comb begin
    phase_nxt     = phase_r;
    in_frame_nxt  = in_frame_r;
    count_nxt     = count_r;
    ext_nxt       = ext_r;
    id_nxt        = id_r;
    id_big_nxt    = id_big_r;
    data_nxt      = data_r;
    bytes_nxt     = bytes_r;
    hi_nxt        = hi_r;
    pend_nxt      = pend_r;
    remote_nxt    = remote_r;
    rlen_nxt      = rlen_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;

    if (beat_take) begin
      if (beat.rx_error) begin
        in_frame_nxt = 1'b0;
      end else if (c == CH_COLON) begin
        in_frame_nxt = 1'b1;
        count_nxt    = CNT_W'(1);
        phase_nxt    = PH_TYPE;
        ext_nxt      = 1'b0;
        id_nxt       = '0;
        id_big_nxt   = 1'b0;
        data_nxt     = '0;
        bytes_nxt    = '0;
        hi_nxt       = '0;
        pend_nxt     = 1'b0;
        remote_nxt   = 1'b0;
        rlen_nxt     = '0;
        bad_nxt      = 1'b0;
      end else if (!in_frame_r) begin
        // idle line, character dropped
      end else if (c == CH_SEMI) begin
        in_frame_nxt = 1'b0;
        if (frame_ok) begin
          out_valid_nxt        = 1'b1;
          out_nxt.is_extended  = ext_r;
          out_nxt.is_remote    = remote_r;
          out_nxt.frame_id     = id_r;
          out_nxt.frame_length = remote_r ? rlen_r : bytes_r;
          out_nxt.frame_data   = remote_r ? 64'd0 : data_r;
        end
      end else if (count_r >= CNT_W'(LINE_CHARS)) begin
        bad_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
        if (!bad_r) begin
          unique case (phase_r)
            PH_TYPE: begin
              if (c == CH_X) begin
                ext_nxt   = 1'b1;
                phase_nxt = PH_ID;
              end else if (c == CH_S) begin
                ext_nxt   = 1'b0;
                phase_nxt = PH_ID;
              end else begin
                bad_nxt = 1'b1;
              end
            end
            PH_ID: begin
              if (hx[4]) begin
                if (id_r > ID_SHIFT_MAX) begin
                  id_big_nxt = 1'b1;
                end else begin
                  id_nxt = {id_r[ID_W-5:0], hx[3:0]};
                end
              end else if (c == CH_N) begin
                phase_nxt = PH_DATA;
              end else if (c == CH_R) begin
                remote_nxt = 1'b1;
                phase_nxt  = PH_RLEN;
              end else begin
                phase_nxt = PH_TAIL;
              end
            end
            PH_DATA: begin
              if (hx[4]) begin
                if (pend_r) begin
                  for (int k = 0; k < 8; k++) begin
                    if (bytes_r[2:0] == 3'(k)) begin
                      data_nxt[63-8*k -: 8] = {hi_r, hx[3:0]};
                    end
                  end
                  bytes_nxt = bytes_r + BC_W'(1);
                  pend_nxt  = 1'b0;
                end else if (bytes_r >= BC_W'(MAX_DATA_BYTES)) begin
                  bad_nxt = 1'b1;
                end else begin
                  hi_nxt   = hx[3:0];
                  pend_nxt = 1'b1;
                end
              end else if (pend_r) begin
                bad_nxt = 1'b1;
              end else begin
                phase_nxt = PH_TAIL;
              end
            end
            PH_RLEN: begin
              if (c >= CH_0 && c <= CH_9) begin
                rlen_nxt = c[3:0];
              end
              phase_nxt = PH_TAIL;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      in_frame_r  <= 1'b0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      in_frame_r  <= in_frame_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ext_r    <= ext_nxt;
    id_r     <= id_nxt;
    id_big_r <= id_big_nxt;
    data_r   <= data_nxt;
    bytes_r  <= bytes_nxt;
    hi_r     <= hi_nxt;
    remote_r <= remote_nxt;
    rlen_r   <= rlen_nxt;
    out_r    <= out_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/acfp_checker.sv -----
// ----------------------------------------------------------------------------
// ASCII CAN frame parser checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module acfp_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire acfp_pkg::frame_t   out_data,
  input wire logic               out_stall
);
  import acfp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_std_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_extended |-> out_data.frame_id <= STD_ID_MAX)
    else $error("standard frame with identifier above 11 bits");

  a_remote_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_remote |-> out_data.frame_data == 64'd0)
    else $error("remote frame carries data");

  a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_remote |-> out_data.frame_length <= 4'(MAX_DATA_BYTES))
    else $error("data frame length above limit");

endmodule

bind ascii_can_frame_parser acfp_checker u_acfp_checker (.*);

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII CAN frame parser testbench
// Sends character beats through the input channel and predicts each CAN
// frame that a line should produce. Every frame on the output channel is
// compared field by field with the oldest prediction. Directed lines cover
// good frames and each rejection rule. Random lines follow: mostly
// well-formed, with noise, error flags and over-long lines mixed in. Both
// channels idle in random bursts, except in the last stretch of traffic.
// ----------------------------------------------------------------------------
module testbench;
  import acfp_pkg::*;

  localparam int LIMIT_CYCLES = 500000;

  typedef enum logic [2:0] {PH_IDLE, PH_TYPE, PH_ID, PH_DATA, PH_RLEN, PH_TAIL} phase_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  rx_beat_t in_data = '0;
  logic     in_stall;
  logic     out_valid;
  frame_t   out_data;
  logic     out_stall = 1'b0;

  ascii_can_frame_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // line parser state
  logic             line_open = 1'b0;
  logic [CNT_W-1:0] line_len = '0;
  phase_t           phase = PH_IDLE;
  logic             is_ext = 1'b0;
  logic [ID_W-1:0]  id_val = '0;
  logic             id_ovf = 1'b0;
  logic [63:0]      data_acc = '0;
  logic [3:0]       nbytes = '0;
  logic [3:0]       hi_nib = '0;
  logic             nib_wait = 1'b0;
  logic             is_rtr = 1'b0;
  logic [3:0]       rtr_len = '0;
  logic             line_bad = 1'b0;

  frame_t   frames_due[$];
  rx_beat_t line_q[$];
  logic     idle_on = 1'b1;
  int       stall_left = 0;
  int       fails = 0;
  int       cycle_cnt = 0;
  int       chars_sent = 0;

  function automatic int hex_nib(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 10;
    if (c >= CH_LA && c <= CH_LF) return c - CH_LA + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic lower);
    if (n < 4'd10) return CH_0 + 8'(n);
    return (lower ? CH_LA : CH_UA) + 8'(n) - 8'd10;
  endfunction

  task automatic parse_char(input logic [7:0] c, input logic err);
    int     h;
    frame_t f;
    h = hex_nib(c);
    if (err) begin
      line_open = 1'b0;
      return;
    end
    if (c == CH_COLON) begin
      line_open = 1'b1;
      line_len = CNT_W'(1);
      phase = PH_TYPE;
      is_ext = 1'b0;
      id_val = '0;
      id_ovf = 1'b0;
      data_acc = '0;
      nbytes = '0;
      hi_nib = '0;
      nib_wait = 1'b0;
      is_rtr = 1'b0;
      rtr_len = '0;
      line_bad = 1'b0;
      return;
    end
    if (!line_open) return;
    if (c == CH_SEMI) begin
      line_open = 1'b0;
      if (!line_bad && line_len < LINE_CHARS && line_len >= 3 && phase != PH_TYPE &&
          !nib_wait && !id_ovf && (is_ext || id_val <= STD_ID_MAX)) begin
        f.is_extended  = is_ext;
        f.is_remote    = is_rtr;
        f.frame_id     = id_val;
        f.frame_length = is_rtr ? rtr_len : nbytes;
        f.frame_data   = (is_rtr || nbytes == 0) ? 64'd0 : data_acc << (8 * (8 - nbytes));
        frames_due.push_back(f);
      end
      return;
    end
    if (line_len >= LINE_CHARS) begin
      line_bad = 1'b1;
      return;
    end
    line_len++;
    if (line_bad) return;
    case (phase)
      PH_TYPE: begin
        if (c == CH_X) begin
          is_ext = 1'b1;
          phase = PH_ID;
        end else if (c == CH_S) begin
          is_ext = 1'b0;
          phase = PH_ID;
        end else begin
          line_bad = 1'b1;
        end
      end
      PH_ID: begin
        if (h >= 0) begin
          if (id_val > (EXT_ID_MAX >> 4)) id_ovf = 1'b1;
          else id_val = {id_val[ID_W-5:0], 4'(h)};
        end else if (c == CH_N) begin
          phase = PH_DATA;
        end else if (c == CH_R) begin
          is_rtr = 1'b1;
          phase = PH_RLEN;
        end else begin
          phase = PH_TAIL;
        end
      end
      PH_DATA: begin
        if (h >= 0) begin
          if (nib_wait) begin
            data_acc = {data_acc[55:0], hi_nib, 4'(h)};
            nbytes++;
            nib_wait = 1'b0;
          end else if (nbytes >= MAX_DATA_BYTES) begin
            line_bad = 1'b1;
          end else begin
            hi_nib = 4'(h);
            nib_wait = 1'b1;
          end
        end else if (nib_wait) begin
          line_bad = 1'b1;
        end else begin
          phase = PH_TAIL;
        end
      end
      PH_RLEN: begin
        if (c >= CH_0 && c <= CH_9) rtr_len = 4'(c - CH_0);
        phase = PH_TAIL;
      end
      default: begin
      end
    endcase
  endtask

  // drive one beat at the falling edge, hold it until taken
  task automatic send_char(input rx_beat_t b);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_data = b;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    parse_char(b.rx_char, b.rx_error);
    chars_sent++;
    @(negedge clk);
  endtask

  function automatic void add_char(input logic [7:0] c, input logic e = 1'b0);
    rx_beat_t b;
    b.rx_char = c;
    b.rx_error = e;
    line_q.push_back(b);
  endfunction

  task automatic send_line();
    while (line_q.size() != 0) send_char(line_q.pop_front());
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
    send_line();
  endtask

  task automatic build_random_line();
    logic ext;
    int   ndig, nb, kind, pos;
    ext = 1'($urandom_range(0, 1));
    add_char(CH_COLON);
    if ($urandom_range(0, 19) == 0) add_char(8'($urandom_range(0, 255)));
    else add_char(ext ? CH_X : CH_S);
    ndig = ext ? $urandom_range(0, 8) : $urandom_range(0, 3);
    if ($urandom_range(0, 19) == 0) ndig = $urandom_range(9, 10);
    for (int i = 0; i < ndig; i++) begin
      if (!ext && ndig == 3 && i == 0 && $urandom_range(0, 9) != 0)
        add_char(hex_char(4'($urandom_range(0, 7)), 1'($urandom_range(0, 1))));
      else
        add_char(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
    end
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      add_char(CH_N);
      nb = ($urandom_range(0, 19) == 0) ? 9 : $urandom_range(0, 8);
      for (int i = 0; i < 2 * nb; i++)
        add_char(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      if ($urandom_range(0, 14) == 0)
        add_char(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
    end else if (kind <= 8) begin
      add_char(CH_R);
      if ($urandom_range(0, 4) != 0) add_char(CH_0 + 8'($urandom_range(0, 9)));
      else add_char(8'($urandom_range(32, 126)));
    end else begin
      add_char(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(32, 126)));
    if ($urandom_range(0, 29) == 0) begin
      pos = $urandom_range(0, line_q.size() - 1);
      line_q.insert(pos, '{rx_char: 8'($urandom_range(0, 255)), rx_error: 1'b0});
    end
    if ($urandom_range(0, 24) == 0) begin
      pos = $urandom_range(0, line_q.size() - 1);
      line_q[pos].rx_error = 1'b1;
    end
    add_char(CH_SEMI);
  endtask

  task automatic test_well_formed_frames();
    send_text(":S123N;");
    send_text(":X1FFFFFFFN0102030405060708;");
    send_text(":S7FFNff;");
    send_text(":XabCdN80fE;");
    send_text(":X0R8;");
    send_text(":S1R9;");
    send_text(":SR;");
    send_text(":XN;");
    send_text(":S5Z99;");
    send_text(":S5N12G34;");
    send_text(":S1RA;");
  endtask

  task automatic test_malformed_frames();
    string s;
    send_text(":S12");
    add_char(CH_N, 1'b1);
    send_line();
    send_text("N;");
    send_text("abc;");
    send_text(":S1:S2N;");
    add_char(CH_COLON, 1'b1);
    send_line();
    send_text("S1N;");
    s = ":X";
    repeat (28) s = {s, "0"};
    send_text({s, "N;"});
    send_text({s, "0N;"});
    send_text(":X;");
    send_text(":S;");
    send_text(":Q12N;");
    send_text(":X200000000N;");
    send_text(":S800N;");
    send_text(":S1N010203040506070809;");
    send_text(":S1N123;");
    send_text(":S1N1Z;");
  endtask

  task automatic test_line_noise();
    rx_beat_t b;
    repeat (150) begin
      b.rx_char = 8'($urandom_range(0, 255));
      b.rx_error = ($urandom_range(0, 7) == 0);
      send_char(b);
    end
  endtask

  task automatic test_random_traffic(input int nchars);
    int stop_at;
    stop_at = chars_sent + nchars;
    while (chars_sent < stop_at) begin
      build_random_line();
      send_line();
    end
  endtask

  // output side stall bursts
  always @(negedge clk) begin
    if (stall_left == 0 && idle_on && $urandom_range(0, 15) == 0)
      stall_left = $urandom_range(1, 13);
    out_stall = (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk) begin
    frame_t exp_f;
    if (rst_n && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        $error("frame received with no frame expected");
        fails++;
      end else begin
        exp_f = frames_due.pop_front();
        if (out_data.is_extended !== exp_f.is_extended) begin
          $error("is_extended expected %0d actual %0d", exp_f.is_extended,
                 out_data.is_extended);
          fails++;
        end
        if (out_data.is_remote !== exp_f.is_remote) begin
          $error("is_remote expected %0d actual %0d", exp_f.is_remote, out_data.is_remote);
          fails++;
        end
        if (out_data.frame_id !== exp_f.frame_id) begin
          $error("frame_id expected %h actual %h", exp_f.frame_id, out_data.frame_id);
          fails++;
        end
        if (out_data.frame_length !== exp_f.frame_length) begin
          $error("frame_length expected %0d actual %0d", exp_f.frame_length,
                 out_data.frame_length);
          fails++;
        end
        if (out_data.frame_data !== exp_f.frame_data) begin
          $error("frame_data expected %h actual %h", exp_f.frame_data, out_data.frame_data);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    test_well_formed_frames();
    test_malformed_frames();
    test_line_noise();
    test_random_traffic(1000);
    idle_on = 1'b0;
    test_random_traffic(200);
    in_valid = 1'b0;
    for (int k = 0; k < 5000 && frames_due.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (frames_due.size() != 0) begin
      $error("%0d expected frames never arrived", frames_due.size());
      fails++;
    end
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
